>>> sv/telemetry_poll_responder_unit_macros.svh
// Assertion macros for the telemetry poll responder.
// Used by the top level only; relies on aclk and aresetn in scope.
`ifndef TELEMETRY_POLL_RESPONDER_UNIT_MACROS_SVH
`define TELEMETRY_POLL_RESPONDER_UNIT_MACROS_SVH

// check a condition in the same cycle
`define TPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the next cycle
`define TPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tpr_pkg.sv
// Shared types and constants of the telemetry poll responder.
// No dependencies; imported by every module of the block but tpr_ram.
package tpr_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int FRAME_W     = 48;

    localparam logic [7:0] SYNC_BYTE       = 8'h7E;
    localparam logic [7:0] ESC_BYTE        = 8'h7D;
    localparam logic [7:0] ESC_XOR         = 8'h20;
    localparam logic [7:0] FRAME_HEAD      = 8'h10;
    localparam logic [7:0] SENSOR_ID_RESET = 8'h1B;

    localparam logic       REQ_RX_BYTE = 1'b0;
    localparam logic       REQ_UPDATE  = 1'b1;

    localparam logic       CFG_SENSOR_ID   = 1'b0;
    localparam logic       CFG_ENTRY_COUNT = 1'b1;

    localparam logic [2:0] POS_HEAD  = 3'd0;
    localparam logic [2:0] POS_ID_LO = 3'd1;
    localparam logic [2:0] POS_ID_HI = 3'd2;
    localparam logic [2:0] POS_VAL0  = 3'd3;
    localparam logic [2:0] POS_VAL1  = 3'd4;
    localparam logic [2:0] POS_VAL2  = 3'd5;
    localparam logic [2:0] POS_VAL3  = 3'd6;
    localparam logic [2:0] POS_CHECK = 3'd7;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  rx_byte;
        logic [3:0]  entry_index;
        logic [15:0] data_id;
        logic [31:0] data_value;
    } tpr_in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } tpr_out_t;

    typedef struct packed {
        logic [15:0] data_id;
        logic [31:0] data_value;
    } tpr_frame_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              empty;
        logic              full;
    } tpr_q_stat_t;

endpackage

>>> sv/tpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/tpr_queue.sv
// Short frame queue between the front and back parts.
// Depends on tpr_pkg for the frame type and queue depth.
module tpr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tpr_pkg::tpr_frame_t push_data,
    input  logic                pop,
    output tpr_pkg::tpr_frame_t pop_data,
    output tpr_pkg::tpr_q_stat_t stat
);
    import tpr_pkg::*;

    tpr_frame_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QLVL_W-1:0] level_reg;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && (level_reg != QLVL_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (level_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   level_reg <= level_reg + 1'b1;
                2'b01:   level_reg <= level_reg - 1'b1;
                default: level_reg <= level_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    assign pop_data   = slot_reg[rptr_reg];
    assign stat.level = level_reg;
    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == QLVL_W'(QUEUE_DEPTH));
endmodule

>>> sv/tpr_front.sv
// Front part: configuration, sensor table, poll detection and entry selection.
// Depends on tpr_pkg and tpr_ram; feeds frames into tpr_queue.
module tpr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tpr_pkg::tpr_in_t     s_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  tpr_pkg::tpr_q_stat_t q_stat,
    output logic                 q_push,
    output tpr_pkg::tpr_frame_t  q_data
);
    import tpr_pkg::*;

    logic [7:0]             sensor_id_reg;
    logic [4:0]             entry_count_reg;
    logic [7:0]             prev_rx_reg;
    logic [IDX_W-1:0]       cur_entry_reg;
    logic [MAX_ENTRIES-1:0] written_reg;
    logic                   pend_reg;
    logic                   pend_written_reg;

    logic                   s_acc;
    logic [CMP_W-1:0]       count_c;
    logic [CMP_W-1:0]       sel_ext;
    logic [CMP_W-1:0]       nxt_ext;
    logic [CMP_W-1:0]       ei_ext;
    logic [IDX_W-1:0]       sel_idx;
    logic [IDX_W-1:0]       cur_next;
    logic [IDX_W-1:0]       wr_idx;
    logic                   is_poll;
    logic                   is_upd;
    logic [FRAME_W-1:0]     rd_data;

    assign cfg_ready = 1'b1;
    assign s_acc     = s_valid && s_ready;
    assign s_ready   = ((QLVL_W + 1)'(q_stat.level) + (QLVL_W + 1)'(pend_reg))
                       < (QLVL_W + 1)'(QUEUE_DEPTH);

    always_comb begin
        count_c = (CMP_W'(entry_count_reg) > CMP_W'(MAX_ENTRIES)) ?
                  CMP_W'(MAX_ENTRIES) : CMP_W'(entry_count_reg);
        sel_ext = (CMP_W'(cur_entry_reg) >= count_c) ? '0 : CMP_W'(cur_entry_reg);
        sel_idx = sel_ext[IDX_W-1:0];
        nxt_ext = sel_ext + 1'b1;
        cur_next = (nxt_ext >= count_c) ? '0 : nxt_ext[IDX_W-1:0];
        ei_ext  = CMP_W'(s_data.entry_index);
        wr_idx  = ei_ext[IDX_W-1:0];
        is_poll = s_acc && (s_data.req_type == REQ_RX_BYTE) && (prev_rx_reg == SYNC_BYTE)
                  && (s_data.rx_byte == sensor_id_reg) && (count_c != '0);
        is_upd  = s_acc && (s_data.req_type == REQ_UPDATE)
                  && (ei_ext < CMP_W'(MAX_ENTRIES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_id_reg    <= SENSOR_ID_RESET;
            entry_count_reg  <= '0;
            prev_rx_reg      <= '0;
            cur_entry_reg    <= '0;
            written_reg      <= '0;
            pend_reg         <= 1'b0;
            pend_written_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SENSOR_ID:   sensor_id_reg   <= cfg_data;
                    CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[4:0];
                    default:         sensor_id_reg   <= sensor_id_reg;
                endcase
            end
            if (s_acc && (s_data.req_type == REQ_RX_BYTE)) begin
                prev_rx_reg <= s_data.rx_byte;
            end
            if (is_poll) begin
                cur_entry_reg    <= cur_next;
                pend_written_reg <= written_reg[sel_idx];
            end
            if (is_upd) begin
                written_reg[wr_idx] <= 1'b1;
            end
            pend_reg <= is_poll;
        end
    end

    tpr_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(MAX_ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (is_upd),
        .waddr(wr_idx),
        .wdata({s_data.data_id, s_data.data_value}),
        .raddr(sel_idx),
        .rdata(rd_data)
    );

    assign q_push = pend_reg;
    assign q_data = pend_written_reg ? tpr_frame_t'(rd_data) : '0;
endmodule

>>> sv/tpr_back.sv
// Back part: frame serializer with checksum, byte stuffing and output register.
// Depends on tpr_pkg; draws frames from tpr_queue.
module tpr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tpr_pkg::tpr_q_stat_t q_stat,
    input  tpr_pkg::tpr_frame_t  q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tpr_pkg::tpr_out_t    m_data,
    output logic                 busy
);
    import tpr_pkg::*;

    logic       busy_reg, busy_next;
    tpr_frame_t frame_reg, frame_next;
    logic [2:0] pos_reg, pos_next;
    logic       esc_reg, esc_next;
    logic [7:0] sum_reg, sum_next;
    logic       m_valid_reg, m_valid_next;
    tpr_out_t   m_data_reg, m_data_next;

    logic       out_free;
    logic [7:0] raw;
    logic [8:0] sum_add;
    logic       advance;

    always_comb begin
        case (pos_reg)
            POS_HEAD:  raw = FRAME_HEAD;
            POS_ID_LO: raw = frame_reg.data_id[7:0];
            POS_ID_HI: raw = frame_reg.data_id[15:8];
            POS_VAL0:  raw = frame_reg.data_value[7:0];
            POS_VAL1:  raw = frame_reg.data_value[15:8];
            POS_VAL2:  raw = frame_reg.data_value[23:16];
            POS_VAL3:  raw = frame_reg.data_value[31:24];
            POS_CHECK: raw = ~sum_reg;
            default:   raw = FRAME_HEAD;
        endcase
    end

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        busy_next    = busy_reg;
        frame_next   = frame_reg;
        pos_next     = pos_reg;
        esc_next     = esc_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        advance      = 1'b0;
        q_pop        = 1'b0;
        sum_add      = {1'b0, sum_reg} + {1'b0, raw};

        if (busy_reg && out_free) begin
            m_valid_next = 1'b1;
            if (esc_reg) begin
                m_data_next.tx_byte   = raw ^ ESC_XOR;
                m_data_next.last_byte = (pos_reg == POS_CHECK);
                esc_next              = 1'b0;
                advance               = 1'b1;
            end else if ((pos_reg != POS_HEAD) && ((raw == SYNC_BYTE) || (raw == ESC_BYTE))) begin
                m_data_next.tx_byte   = ESC_BYTE;
                m_data_next.last_byte = 1'b0;
                esc_next              = 1'b1;
            end else begin
                m_data_next.tx_byte   = raw;
                m_data_next.last_byte = (pos_reg == POS_CHECK);
                advance               = 1'b1;
            end
        end

        if (advance) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == POS_HEAD) begin
                sum_next = FRAME_HEAD;
            end else if (pos_reg == POS_CHECK) begin
                busy_next = 1'b0;
            end else begin
                sum_next = sum_add[7:0] + {7'd0, sum_add[8]};
            end
        end

        if (!busy_reg && !q_stat.empty) begin
            q_pop      = 1'b1;
            busy_next  = 1'b1;
            frame_next = q_data;
            pos_next   = POS_HEAD;
            esc_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            esc_reg     <= 1'b0;
            pos_reg     <= POS_HEAD;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            esc_reg     <= esc_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
        frame_reg  <= frame_next;
        sum_reg    <= sum_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign busy    = busy_reg;
endmodule

>>> sv/telemetry_poll_responder_unit.sv
// Top level of the telemetry poll responder: front, frame queue and back.
// Depends on tpr_pkg, tpr_front, tpr_queue, tpr_back and the macros header.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | tpr_in_t (bus byte or table update)
//  m_      | out       | m_valid / m_ready    | tpr_out_t (stuffed byte, last flag)
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Input transactions are taken one per cycle while the four-frame queue has room.
// A poll frame leaves at one byte per cycle while m_ready is high, 8 to 15 bytes;
// the back part starts the next frame after the last byte and sets the sustained rate.
// Reset is synchronous, active low, and clears the table valid bits at once.
// A stalled m_ready holds the output register; the queue absorbs further polls.
`include "telemetry_poll_responder_unit_macros.svh"

module telemetry_poll_responder_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tpr_pkg::tpr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tpr_pkg::tpr_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import tpr_pkg::*;

    tpr_q_stat_t q_stat;
    tpr_frame_t  q_push_data;
    tpr_frame_t  q_pop_data;
    logic        q_push;
    logic        q_pop;
    logic        back_busy;

    tpr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    tpr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_push_data),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .stat     (q_stat)
    );

    tpr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .busy    (back_busy)
    );

    `TPR_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "frame queue overflow")
    `TPR_ASSERT_NOW(a_stall_has_backlog, !s_ready, q_stat.level != '0, "stall without backlog")
    `TPR_ASSERT_NEXT(a_pop_starts_frame, q_pop, back_busy, "popped frame not started")
endmodule

>>> verif/telemetry_poll_responder_unit_tb.sv
// Self-checking bench for telemetry_poll_responder_unit: table writes, bus bytes and polls
// go in, stuffed response frames come out and are compared against a frame predictor.
// Depends on tpr_pkg and the telemetry_poll_responder_unit top level.
`timescale 1ns / 1ps

module telemetry_poll_responder_unit_tb;
    import tpr_pkg::*;

    localparam int RANDOM_ITEMS  = 450;
    localparam int WAIT_MAX      = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic        is_reg;
        logic        reg_index;
        logic [7:0]  reg_value;
        tpr_in_t     item;
        logic        typed;
        logic [3:0]  typed_count;
        logic [63:0] typed_bytes;
    } step_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tpr_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    tpr_out_t  m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [7:0] cfg_data;

    // frame predictor state
    logic [7:0]  poll_id;
    logic [4:0]  entries_in_use;
    logic [7:0]  last_rx;
    logic [3:0]  next_entry;
    logic [15:0] tbl_ids    [MAX_ENTRIES];
    logic [31:0] tbl_values [MAX_ENTRIES];
    logic        tbl_written[MAX_ENTRIES];

    tpr_out_t predicted_frame[$];
    tpr_out_t pending_tx[$];
    step_t    directed_steps[$];
    bit       no_idle;
    int       mismatch_count;

    telemetry_poll_responder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return SYNC_BYTE;
            1: return ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic tpr_in_t random_item(logic req, logic [7:0] b);
        tpr_in_t it;
        it.req_type    = req;
        it.rx_byte     = b;
        it.entry_index = 4'($urandom_range(0, 15));
        it.data_id     = {rand_byte(), rand_byte()};
        it.data_value  = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        return it;
    endfunction

    function automatic step_t rx_step(logic [7:0] b);
        step_t st;
        st = '0;
        st.item = random_item(REQ_RX_BYTE, b);
        return st;
    endfunction

    function automatic step_t rx_checked(logic [7:0] b, logic [3:0] n, logic [63:0] frame);
        step_t st;
        st = rx_step(b);
        st.typed       = 1'b1;
        st.typed_count = n;
        st.typed_bytes = frame;
        return st;
    endfunction

    function automatic step_t update_step(logic [3:0] idx, logic [15:0] id, logic [31:0] val);
        step_t st;
        st = '0;
        st.item = random_item(REQ_UPDATE, rand_byte());
        st.item.entry_index = idx;
        st.item.data_id     = id;
        st.item.data_value  = val;
        return st;
    endfunction

    function automatic step_t reg_step(logic idx, logic [7:0] val);
        step_t st;
        st = '0;
        st.is_reg    = 1'b1;
        st.reg_index = idx;
        st.reg_value = val;
        return st;
    endfunction

    function automatic void push_stuffed(logic [7:0] b, logic last);
        tpr_out_t ob;
        if (b == SYNC_BYTE || b == ESC_BYTE) begin
            ob.tx_byte   = ESC_BYTE;
            ob.last_byte = 1'b0;
            predicted_frame.push_back(ob);
            b = b ^ ESC_XOR;
        end
        ob.tx_byte   = b;
        ob.last_byte = last;
        predicted_frame.push_back(ob);
    endfunction

    function automatic void predict_response(tpr_in_t it);
        int unsigned in_use;
        int unsigned slot;
        int unsigned sum;
        logic [47:0] payload;
        tpr_out_t    ob;
        predicted_frame.delete();
        if (it.req_type == REQ_UPDATE) begin
            tbl_ids[it.entry_index]     = it.data_id;
            tbl_values[it.entry_index]  = it.data_value;
            tbl_written[it.entry_index] = 1'b1;
            return;
        end
        in_use = (entries_in_use > MAX_ENTRIES) ? MAX_ENTRIES : entries_in_use;
        if (last_rx == SYNC_BYTE && it.rx_byte == poll_id && in_use != 0) begin
            slot    = (next_entry >= in_use) ? 0 : next_entry;
            payload = tbl_written[slot] ? {tbl_values[slot], tbl_ids[slot]} : '0;
            ob.tx_byte   = FRAME_HEAD;
            ob.last_byte = 1'b0;
            predicted_frame.push_back(ob);
            sum = FRAME_HEAD;
            for (int k = 0; k < 6; k++) begin
                push_stuffed(payload[8*k +: 8], 1'b0);
                sum += payload[8*k +: 8];
                sum += sum >> 8;
                sum &= 32'hFF;
            end
            push_stuffed(8'hFF - sum[7:0], 1'b1);
            next_entry = (slot + 1 >= in_use) ? 4'd0 : 4'(slot + 1);
        end
        last_rx = it.rx_byte;
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input tpr_in_t it, input bit use_typed = 1'b0,
                             input logic [3:0] n = '0, input logic [63:0] frame = '0);
        int unsigned gap;
        tpr_out_t    ob;
        gap = no_idle ? 0 : $urandom_range(0, WAIT_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_response(it);
        if (use_typed) begin
            for (int k = 0; k < n; k++) begin
                ob.tx_byte   = frame[63 - 8*k -: 8];
                ob.last_byte = (k == n - 1);
                pending_tx.push_back(ob);
            end
        end else begin
            foreach (predicted_frame[k]) pending_tx.push_back(predicted_frame[k]);
        end
        @(negedge aclk);
    endtask

    // drain outstanding frames, then write one register
    task automatic write_register(input logic idx, input logic [7:0] val);
        s_valid <= 1'b0;
        while (pending_tx.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_SENSOR_ID) poll_id = val;
        else entries_in_use = val[4:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : tx_check
        tpr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tx.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction tx_byte %h last_byte %b",
                                          m_data.tx_byte, m_data.last_byte));
            end else begin
                want = pending_tx.pop_front();
                if (m_data.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte got %h want %h",
                                              m_data.tx_byte, want.tx_byte));
                if (m_data.last_byte !== want.last_byte)
                    report_mismatch($sformatf("last_byte got %b want %b (tx_byte %h)",
                                              m_data.last_byte, want.last_byte, want.tx_byte));
            end
        end
    end

    initial begin : tx_sink
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, WAIT_MAX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int          random_items;
        int          phase;
        int          phase_len;
        int          pick;
        int          drain;
        logic [7:0]  id;
        logic [7:0]  count;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = 1'b0;
        cfg_data       = '0;
        no_idle        = 1'b0;
        mismatch_count = 0;

        poll_id        = SENSOR_ID_RESET;
        entries_in_use = '0;
        last_rx        = '0;
        next_entry     = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            tbl_ids[k]     = '0;
            tbl_values[k]  = '0;
            tbl_written[k] = 1'b0;
        end

        directed_steps = '{
            rx_step(SYNC_BYTE),
            rx_checked(SENSOR_ID_RESET, 4'd0, '0),
            reg_step(CFG_ENTRY_COUNT, 8'd1),
            rx_step(SYNC_BYTE),
            rx_checked(SENSOR_ID_RESET, 4'd8, 64'h1000_0000_0000_00EF),
            update_step(4'd0, 16'hFFFF, 32'hFFFF_FFFF),
            rx_step(SYNC_BYTE),
            rx_checked(SENSOR_ID_RESET, 4'd8, 64'h10FF_FFFF_FFFF_FFEF),
            update_step(4'd1, 16'h7E7D, 32'h7D7E_7E7D),
            update_step(4'd15, 16'h0000, 32'h0000_0000),
            reg_step(CFG_ENTRY_COUNT, 8'd2),
            rx_step(SYNC_BYTE), rx_step(SENSOR_ID_RESET),
            rx_step(SYNC_BYTE), rx_step(SENSOR_ID_RESET),
            rx_step(SYNC_BYTE), rx_step(SENSOR_ID_RESET),
            reg_step(CFG_ENTRY_COUNT, 8'd1),
            rx_step(SYNC_BYTE), rx_step(SENSOR_ID_RESET),
            reg_step(CFG_ENTRY_COUNT, 8'd31),
            reg_step(CFG_SENSOR_ID, SYNC_BYTE),
            rx_step(SYNC_BYTE), rx_step(SYNC_BYTE), rx_step(SYNC_BYTE),
            reg_step(CFG_SENSOR_ID, 8'hFF),
            rx_step(SYNC_BYTE), rx_step(8'hFF),
            reg_step(CFG_SENSOR_ID, 8'h00),
            rx_step(SYNC_BYTE), rx_step(8'h00)
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_reg)
                write_register(directed_steps[k].reg_index, directed_steps[k].reg_value);
            else
                send_item(directed_steps[k].item, directed_steps[k].typed,
                          directed_steps[k].typed_count, directed_steps[k].typed_bytes);
        end

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    id    = 8'hFF;
                    count = 8'd16;
                end
                1: begin
                    id    = 8'h00;
                    count = 8'd31;
                end
                default: begin
                    id    = rand_byte();
                    count = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 31))
                                                         : 8'($urandom_range(1, 16));
                end
            endcase
            write_register(CFG_SENSOR_ID, id);
            write_register(CFG_ENTRY_COUNT, count);
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(30, 80);
            for (int j = 0; j < phase_len && random_items < RANDOM_ITEMS; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_item(random_item(REQ_RX_BYTE, SYNC_BYTE));
                    send_item(random_item(REQ_RX_BYTE, (pick < 42) ? id : rand_byte()));
                    random_items += 2;
                end else if (pick < 75) begin
                    send_item(random_item(REQ_UPDATE, rand_byte()));
                    random_items++;
                end else begin
                    send_item(random_item(REQ_RX_BYTE, rand_byte()));
                    random_items++;
                end
            end
            no_idle = 1'b0;
            phase++;
        end

        s_valid <= 1'b0;
        drain = 0;
        while (pending_tx.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pending_tx.size() != 0)
            report_mismatch($sformatf("%0d expected transactions never arrived",
                                      pending_tx.size()));

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> telemetry_poll_responder_unit.f
+incdir+sv
sv/tpr_pkg.sv
sv/tpr_ram.sv
sv/tpr_queue.sv
sv/tpr_front.sv
sv/tpr_back.sv
sv/telemetry_poll_responder_unit.sv
verif/telemetry_poll_responder_unit_tb.sv
